FILE: rtl/core/spct_pkg.sv
`default_nettype none

package spct_pkg;

  // Coordinate width of one box edge
  localparam int unsigned COORD_BITS = 12;
  // Doubled coordinates and radii
  localparam int unsigned DBL_BITS   = COORD_BITS + 1;
  // Differences of doubled values
  localparam int unsigned DIFF_BITS  = COORD_BITS + 2;
  // Square of one difference, unsigned
  localparam int unsigned SQ_BITS    = 2 * DIFF_BITS - 1;
  // Sum of two squares
  localparam int unsigned SUM_BITS   = SQ_BITS + 1;
  // Corner lanes of the circle/rectangle test
  localparam int unsigned NUM_LANES  = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;

  typedef enum logic [1:0] {
    MODE_RR = 2'd0,
    MODE_CC = 2'd1,
    MODE_CR = 2'd2
  } mode_e;

  // One shape as it enters the block
  typedef struct packed {
    logic   is_circle;
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } shape_t;

  // Geometry stage result
  typedef struct packed {
    mode_e                    mode;
    logic                     rr_hit;
    logic                     band;
    logic                     box_hit;
    logic [NUM_LANES-1:0][DIFF_BITS-1:0] dx;
    logic [NUM_LANES-1:0][DIFF_BITS-1:0] dy;
    logic [DIFF_BITS-1:0]     rad;
  } geom_t;

  // Squared-distance stage result
  typedef struct packed {
    mode_e                    mode;
    logic                     rr_hit;
    logic                     band;
    logic                     box_hit;
    logic                     rad_neg;
    logic [NUM_LANES-1:0][SUM_BITS-1:0] dist2;
    logic [SQ_BITS-1:0]       rad2;
  } sq_t;

endpackage

`default_nettype wire

FILE: rtl/core/spct_geom.sv
`default_nettype none

module spct_geom import spct_pkg::*; (
  input  shape_t a_i,
  input  shape_t b_i,
  output geom_t  geom_o
);

  shape_t c_s;
  shape_t q_s;
  diff_t  cx, cy, rad;
  diff_t  ql, qt, qr, qb;
  diff_t  al, at, ar, ab, bl, bt, br, bb;
  diff_t  cc_dx, cc_dy, cc_sum;
  logic   band;
  logic   box_hit;
  logic   rr_hit;

  // Circle is whichever shape says so; the other is the rectangle
  assign c_s = a_i.is_circle ? a_i : b_i;
  assign q_s = a_i.is_circle ? b_i : a_i;

  // Doubled circle center and radius, doubled rectangle edges
  assign cx  = DIFF_BITS'(c_s.left) + DIFF_BITS'(c_s.right);
  assign cy  = DIFF_BITS'(c_s.top) + DIFF_BITS'(c_s.bottom);
  assign rad = DIFF_BITS'(c_s.right) - DIFF_BITS'(c_s.left);
  assign ql  = DIFF_BITS'(q_s.left) <<< 1;
  assign qt  = DIFF_BITS'(q_s.top) <<< 1;
  assign qr  = DIFF_BITS'(q_s.right) <<< 1;
  assign qb  = DIFF_BITS'(q_s.bottom) <<< 1;

  // Strict band test, then expanded box
  assign band    = (cy > qt && cy < qb) || (cx > ql && cx < qr);
  assign box_hit = (cx >= ql - rad) && (cx <= qr + rad) &&
                   (cy >= qt - rad) && (cy <= qb + rad);

  // Rectangle pair, inclusive overlap
  assign al = DIFF_BITS'(a_i.left);
  assign at = DIFF_BITS'(a_i.top);
  assign ar = DIFF_BITS'(a_i.right);
  assign ab = DIFF_BITS'(a_i.bottom);
  assign bl = DIFF_BITS'(b_i.left);
  assign bt = DIFF_BITS'(b_i.top);
  assign br = DIFF_BITS'(b_i.right);
  assign bb = DIFF_BITS'(b_i.bottom);
  assign rr_hit = (al <= br) && (ar >= bl) && (at <= bb) && (ab >= bt);

  // Circle pair: center offset and radius sum
  assign cc_dx  = (al + ar) - (bl + br);
  assign cc_dy  = (at + ab) - (bt + bb);
  assign cc_sum = (ar - al) + (br - bl);

  // Pack lanes by mode; circle pair uses lane 0
  always_comb begin
    geom_o         = '0;
    geom_o.rr_hit  = rr_hit;
    geom_o.band    = band;
    geom_o.box_hit = box_hit;
    case ({a_i.is_circle, b_i.is_circle})
      2'b00: begin
        geom_o.mode = MODE_RR;
      end
      2'b11: begin
        geom_o.mode  = MODE_CC;
        geom_o.dx[0] = cc_dx;
        geom_o.dy[0] = cc_dy;
        geom_o.rad   = cc_sum;
      end
      default: begin
        geom_o.mode  = MODE_CR;
        geom_o.rad   = rad;
        geom_o.dx[0] = ql - cx;
        geom_o.dy[0] = qt - cy;
        geom_o.dx[1] = ql - cx;
        geom_o.dy[1] = qb - cy;
        geom_o.dx[2] = qr - cx;
        geom_o.dy[2] = qt - cy;
        geom_o.dx[3] = qr - cx;
        geom_o.dy[3] = qb - cy;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/spct_square.sv
`default_nettype none

module spct_square import spct_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  geom_t geom_i,
  output logic  valid_o,
  output sq_t   sq_o
);

  sq_t  sq_d;
  sq_t  sq_q;
  logic valid_q;
  logic signed [2*DIFF_BITS-1:0] px;
  logic signed [2*DIFF_BITS-1:0] py;
  logic signed [2*DIFF_BITS-1:0] pr;

  // One squaring lane per corner plus the radius
  always_comb begin
    sq_d         = '0;
    sq_d.mode    = geom_i.mode;
    sq_d.rr_hit  = geom_i.rr_hit;
    sq_d.band    = geom_i.band;
    sq_d.box_hit = geom_i.box_hit;
    sq_d.rad_neg = geom_i.rad[DIFF_BITS-1];
    pr           = $signed(geom_i.rad) * $signed(geom_i.rad);
    sq_d.rad2    = pr[SQ_BITS-1:0];
    px           = '0;
    py           = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      px = $signed(geom_i.dx[i]) * $signed(geom_i.dx[i]);
      py = $signed(geom_i.dy[i]) * $signed(geom_i.dy[i]);
      sq_d.dist2[i] = SUM_BITS'(px[SQ_BITS-1:0]) + SUM_BITS'(py[SQ_BITS-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  assign valid_o = valid_q;
  assign sq_o    = sq_q;

endmodule

`default_nettype wire

FILE: rtl/core/spct_decide.sv
`default_nettype none

module spct_decide import spct_pkg::*; (
  input  sq_t  sq_i,
  output logic hit_o
);

  logic [NUM_LANES-1:0] lane_ok;

  // Distance within radius; a negative radius never hits
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_ok[i] = !sq_i.rad_neg && (sq_i.dist2[i] <= SUM_BITS'(sq_i.rad2));
    end
  end

  always_comb begin
    case (sq_i.mode)
      MODE_RR: hit_o = sq_i.rr_hit;
      MODE_CC: hit_o = lane_ok[0];
      MODE_CR: hit_o = sq_i.band ? sq_i.box_hit : (|lane_ok);
      default: hit_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/shape_pair_collision_test.sv
// Collision test for a pair of shapes, each a rectangle or a circle given by
// its bounding box in signed pixels.
//
// Request channel: drive the two shapes on the a_* and b_* ports and raise
// start_i. A request is taken at every rising edge with start_i high and
// busy_o low; busy_o is never raised, so a new request can enter every cycle.
//
// Result channel: valid_o is high for exactly one cycle per request, with
// hit_o alongside. Results come out in request order. The request edge loads
// the input register; the request then passes the geometry, squaring and
// result registers in that order. Throughput is one request per cycle.
//
// The receiver cannot stall the block; a result not taken in its cycle is
// gone. Reset clears the valid pipeline, so no stray strobe follows reset.
// Requests in flight at reset are dropped.
`default_nettype none

module shape_pair_collision_test import spct_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  a_is_circle_i,
  input  logic [COORD_BITS-1:0] a_left_i,
  input  logic [COORD_BITS-1:0] a_top_i,
  input  logic [COORD_BITS-1:0] a_right_i,
  input  logic [COORD_BITS-1:0] a_bottom_i,
  input  logic                  b_is_circle_i,
  input  logic [COORD_BITS-1:0] b_left_i,
  input  logic [COORD_BITS-1:0] b_top_i,
  input  logic [COORD_BITS-1:0] b_right_i,
  input  logic [COORD_BITS-1:0] b_bottom_i,
  output logic                  valid_o,
  output logic                  hit_o
);

  shape_t a_q, b_q;
  logic   in_valid_q;
  geom_t  geom_d, geom_q;
  logic   geom_valid_q;
  sq_t    sq;
  logic   sq_valid;
  logic   hit_d, hit_q;
  logic   out_valid_q;

  assign busy_o = 1'b0;

  // Valid bits of the input, geometry and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      geom_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      in_valid_q   <= start_i && !busy_o;
      geom_valid_q <= in_valid_q;
      out_valid_q  <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= '{a_is_circle_i, a_left_i, a_top_i, a_right_i, a_bottom_i};
    b_q    <= '{b_is_circle_i, b_left_i, b_top_i, b_right_i, b_bottom_i};
    geom_q <= geom_d;
    hit_q  <= hit_d;
  end

  // Offsets, band and box tests
  spct_geom u_geom (
    .a_i    (a_q),
    .b_i    (b_q),
    .geom_o (geom_d)
  );

  // Squared distances
  spct_square u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (geom_valid_q),
    .geom_i  (geom_q),
    .valid_o (sq_valid),
    .sq_o    (sq)
  );

  // Final decision into the result register
  spct_decide u_decide (
    .sq_i  (sq),
    .hit_o (hit_d)
  );

  assign valid_o = out_valid_q;
  assign hit_o   = hit_q;

endmodule

`default_nettype wire
